// ----- hw/rtl/awl_pkg.sv -----
// Shared types and constants for the antialiased line stepper.
// Used by awl_div and antialiased_line_stepper; no dependencies.
package awl_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int WEIGHT_BITS    = 8;

  localparam logic [WEIGHT_BITS-1:0] FULL_WEIGHT = 8'd255;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    MODE_VERT  = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_XMAJ  = 2'd2,
    MODE_YMAJ  = 2'd3
  } line_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/awl_div.sv -----
// Restoring divider for the line slope: one compare/subtract per cycle.
// Gives floor(numer * 2^FRAC_BITS / denom) for numer <= denom; uses awl_pkg.
module awl_div #(
  parameter int COORD_BITS = awl_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = awl_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  awl_pkg::div_ctrl_t    ctrl,
  input  logic [COORD_BITS-1:0] numer,
  input  logic [COORD_BITS-1:0] denom,
  output awl_pkg::div_stat_t    stat,
  output logic [FRAC_BITS:0]    quotient
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [COORD_BITS-1:0] den_r, den_nxt;
  logic [FRAC_BITS:0]    quo_r, quo_nxt;
  logic                  ge;
  logic [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]   rem_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    diff     = rem_r - {1'b0, den_r};
    rem_sel  = ge ? diff : rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, numer};
      den_nxt  = denom;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below denom after the subtract, so the shift fits
      rem_nxt = {rem_sel[COORD_BITS-1:0], 1'b0};
      quo_nxt = {quo_r[FRAC_BITS-1:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ----- hw/rtl/antialiased_line_stepper.sv -----
// Antialiased line stepper: loads a line, then gives one pixel per step transaction.
// Latency: every result is registered and appears the cycle after its input transaction.
// Throughput: steps one per cycle unless out_tready stalls; a sloped load holds
// in_tready low while awl_div forms the slope, one quotient bit a cycle, then in ST_ACC.
// Reset (rst_n low, synchronous): no line active, output empty, sequencer idle.
// Depends on awl_pkg and awl_div.
module antialiased_line_stepper #(
  parameter int  COORD_BITS = awl_pkg::COORD_BITS_DEF,
  parameter int  FRAC_BITS  = awl_pkg::FRAC_BITS_DEF,
  localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * COORD_BITS + 2 * awl_pkg::WEIGHT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  input  logic             in_tuser,   // command
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // pixel_x, pixel_y, weight_near, weight_far
  output logic [1:0]       out_tuser,  // has_far, far_along_y
  output logic             out_tlast   // line_done
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int WB    = awl_pkg::WEIGHT_BITS;
  localparam int ACC_W = C + F + 1;
  localparam int PAD_W = OUT_W - 2 * C - 2 * WB;

  awl_pkg::state_t     st_r, st_nxt;
  awl_pkg::line_mode_t mode_r, mode_nxt, ld_mode;
  logic                active_r, active_nxt;
  logic signed [C-1:0] cursor_r, cursor_nxt;
  logic signed [C-1:0] stop_r, stop_nxt;
  logic signed [C-1:0] final_x_r, final_x_nxt;
  logic signed [C-1:0] final_y_r, final_y_nxt;
  logic signed [C-1:0] smin_r, smin_nxt;
  logic                neg_r, neg_nxt;
  logic [ACC_W-1:0]    accum_r, accum_nxt;
  logic [F+1:0]        slope_r, slope_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [C-1:0]        ox_r, ox_nxt, oy_r, oy_nxt;
  logic [WB-1:0]       wn_r, wn_nxt, wf_r, wf_nxt;
  logic                hf_r, hf_nxt, fy_r, fy_nxt, done_r, done_nxt;

  awl_pkg::div_ctrl_t  div_ctrl;
  awl_pkg::div_stat_t  div_stat;
  logic [C-1:0]        div_num, div_den;
  logic [F:0]          quotient;

  logic                in_acc;
  logic signed [C-1:0] sx, sy, ex, ey, osx, osy, oex, oey;
  logic signed [C:0]   dx, dy, adx_w, ady_w, cur1, stop_w;
  logic [C-1:0]        adx, ady;
  logic                x_axis, swap;
  logic [F-1:0]        frac;
  logic [F+WB-1:0]     wprod;
  logic [WB-1:0]       wf_calc;
  logic [C-1:0]        floor_min;

  assign sx = in_tdata[C-1:0];
  assign sy = in_tdata[2*C-1:C];
  assign ex = in_tdata[3*C-1:2*C];
  assign ey = in_tdata[4*C-1:3*C];

  assign in_tready = (st_r == awl_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  awl_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (div_ctrl),
    .numer   (div_num),
    .denom   (div_den),
    .stat    (div_stat),
    .quotient(quotient)
  );

  // load-side classification and endpoint ordering
  always_comb begin
    dx    = {ex[C-1], ex} - {sx[C-1], sx};
    dy    = {ey[C-1], ey} - {sy[C-1], sy};
    adx_w = dx[C] ? -dx : dx;
    ady_w = dy[C] ? -dy : dy;
    adx   = adx_w[C-1:0];
    ady   = ady_w[C-1:0];
    priority if (dx == '0) ld_mode = awl_pkg::MODE_VERT;
    else if (dy == '0)     ld_mode = awl_pkg::MODE_HORIZ;
    else if (ady < adx)    ld_mode = awl_pkg::MODE_XMAJ;
    else                   ld_mode = awl_pkg::MODE_YMAJ;
    x_axis = (ld_mode == awl_pkg::MODE_HORIZ) || (ld_mode == awl_pkg::MODE_XMAJ);
    swap   = x_axis ? (ex < sx) : (ey < sy);
    osx    = swap ? ex : sx;
    osy    = swap ? ey : sy;
    oex    = swap ? sx : ex;
    oey    = swap ? sy : ey;
    div_num = (ld_mode == awl_pkg::MODE_XMAJ) ? ady : adx;
    div_den = (ld_mode == awl_pkg::MODE_XMAJ) ? adx : ady;
  end

  // step-side pixel arithmetic
  always_comb begin
    cur1      = {cursor_r[C-1], cursor_r} + 1'b1;
    stop_w    = {stop_r[C-1], stop_r};
    frac      = accum_r[F-1:0];
    wprod     = {frac, {WB{1'b0}}} - {{WB{1'b0}}, frac};
    wf_calc   = wprod[F+WB-1:F];
    floor_min = accum_r[F+C-1:F];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= awl_pkg::ST_IDLE;
      mode_r      <= awl_pkg::MODE_VERT;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cursor_r  <= cursor_nxt;
    stop_r    <= stop_nxt;
    final_x_r <= final_x_nxt;
    final_y_r <= final_y_nxt;
    smin_r    <= smin_nxt;
    neg_r     <= neg_nxt;
    accum_r   <= accum_nxt;
    slope_r   <= slope_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    wn_r      <= wn_nxt;
    wf_r      <= wf_nxt;
    hf_r      <= hf_nxt;
    fy_r      <= fy_nxt;
    done_r    <= done_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    mode_nxt      = mode_r;
    active_nxt    = active_r;
    cursor_nxt    = cursor_r;
    stop_nxt      = stop_r;
    final_x_nxt   = final_x_r;
    final_y_nxt   = final_y_r;
    smin_nxt      = smin_r;
    neg_nxt       = neg_r;
    accum_nxt     = accum_r;
    slope_nxt     = slope_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    wn_nxt        = wn_r;
    wf_nxt        = wf_r;
    hf_nxt        = hf_r;
    fy_nxt        = fy_r;
    done_nxt      = done_r;
    div_ctrl      = '0;

    unique case (st_r)
      awl_pkg::ST_IDLE: begin
        if (in_acc && in_tuser == awl_pkg::CMD_LOAD) begin
          out_valid_nxt = 1'b1;
          wn_nxt        = awl_pkg::FULL_WEIGHT;
          wf_nxt        = '0;
          hf_nxt        = 1'b0;
          fy_nxt        = 1'b0;
          if (dx == '0 && dy == '0) begin
            // single point: emit it as the end and stay inactive
            active_nxt  = 1'b0;
            mode_nxt    = awl_pkg::MODE_VERT;
            cursor_nxt  = sy;
            stop_nxt    = sy;
            final_x_nxt = sx;
            final_y_nxt = sy;
            ox_nxt      = sx;
            oy_nxt      = sy;
            done_nxt    = 1'b1;
          end else begin
            active_nxt  = 1'b1;
            mode_nxt    = ld_mode;
            cursor_nxt  = x_axis ? osx : osy;
            stop_nxt    = x_axis ? oex : oey;
            final_x_nxt = oex;
            final_y_nxt = oey;
            ox_nxt      = osx;
            oy_nxt      = osy;
            done_nxt    = 1'b0;
            if (ld_mode == awl_pkg::MODE_XMAJ) begin
              smin_nxt = osy;
              neg_nxt  = dy[C] ^ swap;
            end else begin
              smin_nxt = osx;
              neg_nxt  = dx[C] ^ swap;
            end
            if (ld_mode == awl_pkg::MODE_XMAJ || ld_mode == awl_pkg::MODE_YMAJ) begin
              div_ctrl.start = 1'b1;
              st_nxt         = awl_pkg::ST_DIV;
            end
          end
        end else if (in_acc && active_r) begin
          out_valid_nxt = 1'b1;
          cursor_nxt    = cur1[C-1:0];
          wn_nxt        = awl_pkg::FULL_WEIGHT;
          wf_nxt        = '0;
          hf_nxt        = 1'b0;
          fy_nxt        = 1'b0;
          done_nxt      = 1'b0;
          if (cur1 >= stop_w) begin
            active_nxt = 1'b0;
            ox_nxt     = final_x_r;
            oy_nxt     = final_y_r;
            done_nxt   = 1'b1;
          end else begin
            unique case (mode_r)
              awl_pkg::MODE_VERT: begin
                ox_nxt = final_x_r;
                oy_nxt = cur1[C-1:0];
              end
              awl_pkg::MODE_HORIZ: begin
                ox_nxt = cur1[C-1:0];
                oy_nxt = final_y_r;
              end
              awl_pkg::MODE_XMAJ: begin
                ox_nxt    = cur1[C-1:0];
                oy_nxt    = floor_min;
                wn_nxt    = awl_pkg::FULL_WEIGHT - wf_calc;
                wf_nxt    = wf_calc;
                hf_nxt    = 1'b1;
                fy_nxt    = 1'b1;
                accum_nxt = accum_r + {{(ACC_W-F-2){slope_r[F+1]}}, slope_r};
              end
              awl_pkg::MODE_YMAJ: begin
                ox_nxt    = floor_min;
                oy_nxt    = cur1[C-1:0];
                wn_nxt    = awl_pkg::FULL_WEIGHT - wf_calc;
                wf_nxt    = wf_calc;
                hf_nxt    = 1'b1;
                accum_nxt = accum_r + {{(ACC_W-F-2){slope_r[F+1]}}, slope_r};
              end
              default: begin
                ox_nxt = ox_r;
              end
            endcase
          end
        end
      end
      awl_pkg::ST_DIV: begin
        if (div_stat.done) begin
          slope_nxt = neg_r ? -{1'b0, quotient} : {1'b0, quotient};
          st_nxt    = awl_pkg::ST_ACC;
        end
      end
      awl_pkg::ST_ACC: begin
        // first minor position: start minor plus one slope step
        accum_nxt = {smin_r[C-1], smin_r, {F{1'b0}}}
                  + {{(ACC_W-F-2){slope_r[F+1]}}, slope_r};
        st_nxt    = awl_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = awl_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, wf_r, wn_r, oy_r, ox_r};
  assign out_tuser  = {fy_r, hf_r};
  assign out_tlast  = done_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> st_r == awl_pkg::ST_DIV)
    else $error("divider finished outside the slope state");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == awl_pkg::ST_DIV && !div_stat.done) |-> div_stat.busy)
    else $error("slope state waiting on an idle divider");

  a_acc_sloped: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == awl_pkg::ST_ACC) |->
      active_r && (mode_r == awl_pkg::MODE_XMAJ || mode_r == awl_pkg::MODE_YMAJ))
    else $error("accumulator set-up for a line that is not sloped");

  a_cursor_below_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && st_r == awl_pkg::ST_IDLE) |-> cursor_r < stop_r)
    else $error("active line with cursor at or past its end");

endmodule
